/* design/obdpid_pkg.sv */
// ----------------------------------------------------------------------------
// obdpid_pkg
// Shared constants, formula codes, types and a hex-digit function for the OBD-II PID reply decoder.
// ----------------------------------------------------------------------------
package obdpid_pkg;

    localparam int VALUE_W = 21;

    // characters of the adapter reply
    localparam logic [7:0] PROMPT_CHAR  = 8'h3E;
    localparam logic [7:0] HDR0_CHAR    = 8'h34;
    localparam logic [7:0] HDR1_CHAR    = 8'h31;
    localparam logic [7:0] DIGIT_BASE   = 8'h30;
    localparam logic [7:0] DIGIT_LAST   = 8'h39;
    localparam logic [7:0] LETTER_FIRST = 8'h41;
    localparam logic [7:0] LETTER_LAST  = 8'h46;
    localparam logic [7:0] LETTER_BASE  = 8'h37;

    // scaling constants
    localparam logic [VALUE_W-1:0] TEMP_OFFSET = VALUE_W'(8'h28);
    localparam logic [6:0]         LOAD_MUL    = 7'h64;
    // floor(w/100) = (w * DIV100_MUL) >> DIV100_SHIFT, exact for w < 2**16
    localparam int                 DIV100_SHIFT = 23;
    localparam logic [16:0]        DIV100_MUL   = 17'd83887;

    // formula select codes
    localparam logic [2:0] FORM_RAW  = 3'd0;
    localparam logic [2:0] FORM_TEMP = 3'd1;
    localparam logic [2:0] FORM_LOAD = 3'd2;
    localparam logic [2:0] FORM_RPM  = 3'd3;
    localparam logic [2:0] FORM_DIST = 3'd4;
    localparam logic [2:0] FORM_MAF  = 3'd5;
    localparam logic [2:0] FORM_RAIL = 3'd6;

    // one captured reply, waiting to be scaled
    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic       positive;
        logic [2:0] formula;
    } reply_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= LETTER_FIRST && c <= LETTER_LAST) begin
            d = c - LETTER_BASE;
        end else if (c >= DIGIT_BASE && c <= DIGIT_LAST) begin
            d = c - DIGIT_BASE;
        end
        return d[3:0];
    endfunction

endpackage

/* design/obdpid_scale.sv */
// ----------------------------------------------------------------------------
// obdpid_scale
// Applies the selected PID formula to data bytes A and B of one reply.
// ----------------------------------------------------------------------------
module obdpid_scale
    import obdpid_pkg::*;
(
    input  reply_t                    reply,
    output logic signed [VALUE_W-1:0] value,
    output logic                      status
);

    logic [15:0] word;
    logic [14:0] load_prod;
    logic [15:0] load_sum;
    logic [7:0]  load_q;
    logic [32:0] maf_prod;
    logic [19:0] rail;
    logic [VALUE_W-1:0] result;

    assign word = {reply.byte_a, reply.byte_b};

    // floor(x/255) = (x + 1 + (x >> 8)) >> 8 for x below 65535
    assign load_prod = 15'(reply.byte_a) * 15'(LOAD_MUL);
    assign load_sum  = 16'(load_prod) + 16'd1 + 16'(load_prod >> 8);
    assign load_q    = load_sum[15:8];

    assign maf_prod = 33'(word) * 33'(DIV100_MUL);

    assign rail = (20'(word) << 3) + (20'(word) << 1);

    always_comb begin
        unique case (reply.formula)
            FORM_TEMP: result = VALUE_W'(reply.byte_a) - TEMP_OFFSET;
            FORM_LOAD: result = VALUE_W'(load_q);
            FORM_RPM:  result = VALUE_W'(word[15:2]);
            FORM_DIST: result = VALUE_W'(word);
            FORM_MAF:  result = VALUE_W'(maf_prod[32:DIV100_SHIFT]);
            FORM_RAIL: result = VALUE_W'(rail);
            default:   result = VALUE_W'(reply.byte_a);
        endcase
    end

    assign value  = reply.positive ? signed'(result) : '0;
    assign status = !reply.positive;

endmodule

/* design/obd_pid_response_decoder.sv */
// ----------------------------------------------------------------------------
// obd_pid_response_decoder
// Decodes an OBD-II mode 01 reply, one ASCII byte per transfer, into a value.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while s_ready is high; the reply state
//   updates on the accepting edge. The edge that accepts the '>' byte loads
//   the capture register; m_valid rises when the result register loads from it.
// A two-deep path (capture + result) keeps bytes flowing while a result waits.
// Reset (aresetn low, synchronous): position, header flags, data bytes and
//   both valid flags clear.
module obd_pid_response_decoder
    import obdpid_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_ch,
    input  logic [2:0]                s_formula,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_value,
    output logic                      m_status
);

    localparam logic [3:0] POS_HDR0 = 4'd0;
    localparam logic [3:0] POS_HDR1 = 4'd1;
    localparam logic [3:0] POS_AHI  = 4'd4;
    localparam logic [3:0] POS_ALO  = 4'd5;
    localparam logic [3:0] POS_BHI  = 4'd6;
    localparam logic [3:0] POS_BLO  = 4'd7;
    localparam logic [3:0] POS_END  = 4'd8;

    logic [3:0] position_reg, position_next;
    logic [1:0] header_reg, header_next;
    logic [7:0] byte_a_reg, byte_a_next;
    logic [7:0] byte_b_reg, byte_b_next;

    reply_t capt_reg;
    logic   capt_valid_reg;
    logic   out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic   out_status_reg;

    logic   in_xfer;
    logic   is_prompt;
    logic   out_load;
    logic [3:0] nib;
    logic signed [VALUE_W-1:0] scaled_value;
    logic   scaled_status;

    assign out_load  = !out_valid_reg || m_ready;
    assign s_ready   = !capt_valid_reg || out_load;
    assign in_xfer   = s_valid && s_ready;
    assign is_prompt = (s_ch == PROMPT_CHAR);
    assign nib       = hex_nibble(s_ch);

    always_comb begin
        position_next = position_reg;
        header_next   = header_reg;
        byte_a_next   = byte_a_reg;
        byte_b_next   = byte_b_reg;
        if (in_xfer) begin
            if (is_prompt) begin
                position_next = '0;
                header_next   = '0;
                byte_a_next   = '0;
                byte_b_next   = '0;
            end else begin
                unique case (position_reg)
                    POS_HDR0: if (s_ch == HDR0_CHAR) header_next[0] = 1'b1;
                    POS_HDR1: if (s_ch == HDR1_CHAR) header_next[1] = 1'b1;
                    POS_AHI:  byte_a_next[7:4] = nib;
                    POS_ALO:  byte_a_next[3:0] = nib;
                    POS_BHI:  byte_b_next[7:4] = nib;
                    POS_BLO:  byte_b_next[3:0] = nib;
                    default:  ;
                endcase
                if (position_reg < POS_END) begin
                    position_next = position_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            header_reg   <= '0;
            byte_a_reg   <= '0;
            byte_b_reg   <= '0;
        end else begin
            position_reg <= position_next;
            header_reg   <= header_next;
            byte_a_reg   <= byte_a_next;
            byte_b_reg   <= byte_b_next;
        end
    end

    // capture the finished reply on the prompt transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capt_valid_reg <= 1'b0;
        end else if (in_xfer && is_prompt) begin
            capt_valid_reg <= 1'b1;
        end else if (out_load) begin
            capt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && is_prompt) begin
            capt_reg.byte_a   <= byte_a_reg;
            capt_reg.byte_b   <= byte_b_reg;
            capt_reg.positive <= (header_reg == 2'b11);
            capt_reg.formula  <= s_formula;
        end
    end

    obdpid_scale u_scale (
        .reply  (capt_reg),
        .value  (scaled_value),
        .status (scaled_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= capt_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && capt_valid_reg) begin
            out_value_reg  <= scaled_value;
            out_status_reg <= scaled_status;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_status = out_status_reg;

`ifndef SYNTHESIS
    a_prompt_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && is_prompt) |=> capt_valid_reg)
        else $error("prompt transfer not captured");

    a_reply_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && is_prompt) |=> (position_reg == '0 && header_reg == '0))
        else $error("reply state not cleared after prompt");

    a_negative_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_value == '0))
        else $error("non-positive reply carries a value");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (capt_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted with both stages full");
`endif

endmodule
